### design/vau_pkg.sv
`default_nettype none
package vau_pkg;

  localparam logic [4:0] FMT_R32G32B32A32_FLOAT = 5'd0;
  localparam logic [4:0] FMT_R32G32B32_FLOAT    = 5'd1;
  localparam logic [4:0] FMT_R32G32_FLOAT       = 5'd2;
  localparam logic [4:0] FMT_R32_FLOAT          = 5'd3;
  localparam logic [4:0] FMT_R16G16B16A16_FLOAT = 5'd4;
  localparam logic [4:0] FMT_R16G16_FLOAT       = 5'd5;
  localparam logic [4:0] FMT_R8G8B8A8_UNORM     = 5'd6;
  localparam logic [4:0] FMT_B8G8R8A8_UNORM     = 5'd7;
  localparam logic [4:0] FMT_B8G8R8X8_UNORM     = 5'd8;
  localparam logic [4:0] FMT_R8G8B8A8_SNORM     = 5'd9;
  localparam logic [4:0] FMT_R8G8B8A8_UINT      = 5'd10;
  localparam logic [4:0] FMT_R8G8B8A8_SINT      = 5'd11;
  localparam logic [4:0] FMT_R32G32B32A32_UINT  = 5'd12;
  localparam logic [4:0] FMT_R32G32B32A32_SINT  = 5'd13;
  localparam logic [4:0] FMT_R10G10B10A2_UNORM  = 5'd14;
  localparam logic [4:0] FMT_R16G16_SNORM       = 5'd15;
  localparam logic [4:0] FMT_R16G16_UNORM       = 5'd16;
  localparam logic [4:0] FMT_R16G16_UINT        = 5'd17;
  localparam logic [4:0] FMT_R16G16_SINT        = 5'd18;

  localparam logic [31:0] ONE_F  = 32'h3F80_0000;
  localparam logic [31:0] QNAN_F = 32'h7FC0_0000;
  localparam logic [31:0] INT_ONE = 32'd1;

  localparam int NumLanes = 4;

  typedef struct packed {
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
    logic [31:0] comp_w;
  } vau_result_t;

endpackage
`default_nettype wire

### design/vau_lane.sv
`default_nettype none
module vau_lane (
  input  wire logic [4:0]  format_code,
  input  wire logic [63:0] raw_low,
  input  wire logic [63:0] raw_high,
  input  wire logic [1:0]  lane_idx,
  output logic      [31:0] comp
);
  import vau_pkg::*;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] sh;
    logic       found;
    logic [10:0] mm;
    logic [7:0] ex;
    e = h[14:10];
    m = h[9:0];
    sh = 4'd0;
    found = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (!found && m[9 - i]) begin
        sh = 4'(i + 1);
        found = 1'b1;
      end
    end
    mm = {1'b0, m} << sh;
    ex = 8'd113 - 8'(sh);
    if (e == 5'd0) begin
      half_to_single = (m == 10'd0) ? {h[15], 31'd0} : {h[15], ex, mm[9:0], 13'd0};
    end else if (e == 5'h1F) begin
      half_to_single = (m == 10'd0) ? {h[15], 31'h7F80_0000} : QNAN_F;
    end else begin
      half_to_single = {h[15], 8'(e) + 8'd112, m, 13'd0};
    end
  endfunction

  // n / (2^b - 1): the fraction is n repeated forever, so no rounding ties
  function automatic logic [31:0] norm_conv(input logic [15:0] mag, input logic [4:0] b,
                                            input logic neg);
    logic [63:0] t;
    logic [47:0] f;
    logic [15:0] den;
    logic [3:0]  lz;
    logic        found;
    logic [47:0] sh;
    logic [24:0] mr;
    logic [7:0]  ex;
    den = 16'hFFFF >> (5'd16 - b);
    t = 64'd0;
    unique case (b)
      5'd2:    t = {16'd0, {24{mag[1:0]}}};
      5'd7:    t = {15'd0, {7{mag[6:0]}}} << 15;
      5'd8:    t = {16'd0, {6{mag[7:0]}}};
      5'd10:   t = {14'd0, {5{mag[9:0]}}} << 14;
      5'd15:   t = {4'd0, {4{mag[14:0]}}} << 4;
      default: t = {16'd0, {3{mag}}};
    endcase
    f = t[63:16] | t[47:0] & {48{1'b0}};
    if (b == 5'd2 || b == 5'd8 || b == 5'd16) f = t[47:0];
    lz = 4'd0;
    found = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (!found && f[47 - i]) begin
        lz = 4'(i);
        found = 1'b1;
      end
    end
    sh = f << lz;
    mr = {1'b0, sh[47:24]} + 25'(sh[23]);
    ex = 8'd126 - 8'(lz) + 8'(mr[24]);
    if (mag == 16'd0) norm_conv = 32'd0;
    else if (mag >= den) norm_conv = {neg, ONE_F[30:0]};
    else norm_conv = {neg, ex, mr[22:0]};
  endfunction

  logic [31:0] word;
  logic [15:0] half;
  logic [7:0]  byt;
  logic [7:0]  bgra_byt;
  logic [31:0] fill;
  logic [9:0]  rgb10;
  logic        lo2;
  logic        lo3;

  always_comb begin
    unique case (lane_idx)
      2'd0:    begin word = raw_low[31:0];   bgra_byt = raw_low[23:16]; end
      2'd1:    begin word = raw_low[63:32];  bgra_byt = raw_low[15:8];  end
      2'd2:    begin word = raw_high[31:0];  bgra_byt = raw_low[7:0];   end
      default: begin word = raw_high[63:32]; bgra_byt = raw_low[31:24]; end
    endcase
    half  = raw_low[16 * lane_idx +: 16];
    byt   = raw_low[8 * lane_idx +: 8];
    rgb10 = raw_low[10 * lane_idx +: 10];
    fill  = (lane_idx == 2'd3) ? ONE_F : 32'd0;
    lo2   = (lane_idx < 2'd2);
    lo3   = (lane_idx < 2'd3);
  end

  always_comb begin
    unique case (format_code)
      FMT_R32G32B32A32_FLOAT, FMT_R32G32B32A32_UINT, FMT_R32G32B32A32_SINT: comp = word;
      FMT_R32G32B32_FLOAT:    comp = lo3 ? word : fill;
      FMT_R32G32_FLOAT:       comp = lo2 ? word : fill;
      FMT_R32_FLOAT:          comp = (lane_idx == 2'd0) ? word : fill;
      FMT_R16G16B16A16_FLOAT: comp = half_to_single(half);
      FMT_R16G16_FLOAT:       comp = lo2 ? half_to_single(half) : fill;
      FMT_R8G8B8A8_UNORM:     comp = norm_conv({8'd0, byt}, 5'd8, 1'b0);
      FMT_B8G8R8A8_UNORM, FMT_B8G8R8X8_UNORM:
        comp = norm_conv({8'd0, bgra_byt}, 5'd8, 1'b0);
      FMT_R8G8B8A8_SNORM:
        comp = norm_conv(byt[7] ? 16'(9'h100 - {1'b0, byt}) : {8'd0, byt}, 5'd7, byt[7]);
      FMT_R8G8B8A8_UINT:      comp = {24'd0, byt};
      FMT_R8G8B8A8_SINT:      comp = {{24{byt[7]}}, byt};
      FMT_R10G10B10A2_UNORM:
        comp = lo3 ? norm_conv({6'd0, rgb10}, 5'd10, 1'b0)
                   : norm_conv({14'd0, raw_low[31:30]}, 5'd2, 1'b0);
      FMT_R16G16_SNORM:
        comp = lo2 ? norm_conv(half[15] ? 16'(17'h10000 - {1'b0, half}) : half, 5'd15, half[15])
                   : fill;
      FMT_R16G16_UNORM:       comp = lo2 ? norm_conv(half, 5'd16, 1'b0) : fill;
      FMT_R16G16_UINT:
        comp = lo2 ? {16'd0, half} : ((lane_idx == 2'd3) ? INT_ONE : 32'd0);
      FMT_R16G16_SINT:
        comp = lo2 ? {{16{half[15]}}, half} : ((lane_idx == 2'd3) ? INT_ONE : 32'd0);
      default:                comp = fill;
    endcase
  end

endmodule
`default_nettype wire

### design/vau_merge.sv
`default_nettype none
module vau_merge (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire vau_pkg::vau_result_t lane_res,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output vau_pkg::vau_result_t      out_res
);
  import vau_pkg::*;

  logic        out_v_r, out_v_nxt;
  logic        skid_v_r, skid_v_nxt;
  vau_result_t out_d_r, skid_d_r;
  logic        acc;
  logic        out_take;

  assign in_stall  = skid_v_r;
  assign acc       = in_valid && !skid_v_r;
  assign out_take  = !out_v_r || !out_stall;
  assign out_valid = out_v_r;
  assign out_res   = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (out_take) begin
      out_v_nxt  = skid_v_r || acc;
      skid_v_nxt = 1'b0;
    end else if (acc) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_d_r <= skid_v_r ? skid_d_r : lane_res;
    end else if (acc) begin
      skid_d_r <= lane_res;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds an item while output is empty");
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall && acc) |=> skid_v_r) else $error("stalled item not parked");
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_stall) |=> (out_v_r && !skid_v_r)) else $error("skid did not drain");

endmodule
`default_nettype wire

### design/vertex_attribute_unpack.sv
`default_nettype none
// an accepted item is registered into the output register, or into the skid register first when the output stalls
// throughput: 1 item per cycle while in_stall is low; four conversion lanes work in parallel
// an output register and a skid register give two entries, so one more item is taken after an output stall
// reset: synchronous active-low rst_n clears the output and skid valid flags
module vertex_attribute_unpack (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [4:0]  in_format_code,
  input  wire logic [63:0] in_raw_low,
  input  wire logic [63:0] in_raw_high,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] out_comp_x,
  output logic      [31:0] out_comp_y,
  output logic      [31:0] out_comp_z,
  output logic      [31:0] out_comp_w
);
  import vau_pkg::*;

  logic [31:0] lane_comp [NumLanes];
  vau_result_t lane_res;
  vau_result_t res;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    vau_lane u_lane (
      .format_code (in_format_code),
      .raw_low     (in_raw_low),
      .raw_high    (in_raw_high),
      .lane_idx    (2'(g)),
      .comp        (lane_comp[g])
    );
  end

  assign lane_res = '{comp_x: lane_comp[0], comp_y: lane_comp[1],
                      comp_z: lane_comp[2], comp_w: lane_comp[3]};

  vau_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .lane_res  (lane_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_comp_x = res.comp_x;
  assign out_comp_y = res.comp_y;
  assign out_comp_z = res.comp_z;
  assign out_comp_w = res.comp_w;

endmodule
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import vau_pkg::*;

  typedef struct {
    logic [4:0]  fmt;
    logic [63:0] lo;
    logic [63:0] hi;
    bit          drain;
  } element_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  in_format_code = '0;
  logic [63:0] in_raw_low = '0;
  logic [63:0] in_raw_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_comp_x, out_comp_y, out_comp_z, out_comp_w;

  element_t    pending_elements[$];
  vau_result_t expected_components[$];
  int          error_count = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  bit          item_taken = 1'b0;
  bit          tail_phase = 1'b0;

  vertex_attribute_unpack dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_format_code, .in_raw_low, .in_raw_high,
    .out_valid, .out_stall, .out_comp_x, .out_comp_y, .out_comp_z, .out_comp_w
  );

  always #2 clk = ~clk;

  // round a double in [-1, 1] to the nearest single, ties to even
  function automatic logic [31:0] to_single(real r);
    logic [63:0] d;
    logic [23:0] m;
    logic [28:0] rest;
    logic [8:0]  e;
    d = $realtobits(r);
    if (d[62:0] == '0) return {d[63], 31'd0};
    e = 9'(d[62:52] - 11'd1023 + 11'd127);
    m = {1'b0, d[51:29]};
    rest = d[28:0];
    if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && m[0])) m = m + 24'd1;
    if (m[23]) begin
      e = e + 9'd1;
      m = '0;
    end
    return {d[63], e[7:0], m[22:0]};
  endfunction

  function automatic logic [31:0] unorm_value(logic [31:0] n, real d);
    return to_single(real'(n) / d);
  endfunction

  function automatic logic [31:0] snorm_value(logic [31:0] n, int bits, real d);
    int v;
    v = n[bits-1] ? int'(n) - (1 << bits) : int'(n);
    if (v == -(1 << (bits - 1))) return 32'hBF80_0000;
    if (v == 0) return 32'd0;
    return to_single(real'(v) / d);
  endfunction

  function automatic logic [31:0] half_value(logic [15:0] h);
    logic [31:0] s;
    logic [7:0]  ex;
    logic [10:0] m;
    s = {h[15], 31'd0};
    m = {1'b0, h[9:0]};
    if (h[14:10] == 5'd0) begin
      if (m == 11'd0) return s;
      ex = 8'd113;
      while (!m[10]) begin
        m = m << 1;
        ex = ex - 8'd1;
      end
      return s | {1'b0, ex, m[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) return (h[9:0] == 10'd0) ? (s | 32'h7F80_0000) : QNAN_F;
    return s | {1'b0, 3'b000, h[14:10] + 5'd0, 23'd0} + {1'b0, 8'd112, 23'd0}
             | {9'd0, h[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] sign_extend(logic [31:0] n, int bits);
    return n[bits-1] ? (n | ~((32'd1 << bits) - 1)) : n;
  endfunction

  function automatic vau_result_t convert_element(logic [4:0] fmt, logic [63:0] lo,
                                                  logic [63:0] hi);
    logic [3:0][31:0] c;
    logic [3:0][31:0] w;
    logic [3:0][15:0] h;
    logic [3:0][7:0]  b;
    c = {32'd0, 32'd0, 32'd0, ONE_F};
    w = {lo[31:0], lo[63:32], hi[31:0], hi[63:32]};
    h = {lo[15:0], lo[31:16], lo[47:32], lo[63:48]};
    b = {lo[7:0], lo[15:8], lo[23:16], lo[31:24]};
    // index 3 is x, index 0 is w
    case (fmt)
      FMT_R32G32B32A32_FLOAT, FMT_R32G32B32A32_UINT, FMT_R32G32B32A32_SINT: c = w;
      FMT_R32G32B32_FLOAT: c = {w[3], w[2], w[1], ONE_F};
      FMT_R32G32_FLOAT: c = {w[3], w[2], 32'd0, ONE_F};
      FMT_R32_FLOAT: c = {w[3], 32'd0, 32'd0, ONE_F};
      FMT_R16G16B16A16_FLOAT:
        for (int i = 0; i < 4; i++) c[i] = half_value(h[i]);
      FMT_R16G16_FLOAT: c = {half_value(h[3]), half_value(h[2]), 32'd0, ONE_F};
      FMT_R8G8B8A8_UNORM:
        for (int i = 0; i < 4; i++) c[i] = unorm_value(32'(b[i]), 255.0);
      FMT_B8G8R8A8_UNORM, FMT_B8G8R8X8_UNORM:
        c = {unorm_value(32'(b[1]), 255.0), unorm_value(32'(b[2]), 255.0),
             unorm_value(32'(b[3]), 255.0), unorm_value(32'(b[0]), 255.0)};
      FMT_R8G8B8A8_SNORM:
        for (int i = 0; i < 4; i++) c[i] = snorm_value(32'(b[i]), 8, 127.0);
      FMT_R8G8B8A8_UINT:
        for (int i = 0; i < 4; i++) c[i] = {24'd0, b[i]};
      FMT_R8G8B8A8_SINT:
        for (int i = 0; i < 4; i++) c[i] = sign_extend(32'(b[i]), 8);
      FMT_R10G10B10A2_UNORM:
        c = {unorm_value(32'(w[3][9:0]), 1023.0), unorm_value(32'(w[3][19:10]), 1023.0),
             unorm_value(32'(w[3][29:20]), 1023.0), unorm_value(32'(w[3][31:30]), 3.0)};
      FMT_R16G16_SNORM:
        c = {snorm_value(32'(h[3]), 16, 32767.0), snorm_value(32'(h[2]), 16, 32767.0),
             32'd0, ONE_F};
      FMT_R16G16_UNORM:
        c = {unorm_value(32'(h[3]), 65535.0), unorm_value(32'(h[2]), 65535.0),
             32'd0, ONE_F};
      FMT_R16G16_UINT: c = {16'd0, h[3], 16'd0, h[2], 32'd0, INT_ONE};
      FMT_R16G16_SINT:
        c = {sign_extend(32'(h[3]), 16), sign_extend(32'(h[2]), 16), 32'd0, INT_ONE};
      default: ;
    endcase
    return vau_result_t'(c);
  endfunction

  task automatic add_element(logic [4:0] fmt, logic [63:0] lo, logic [63:0] hi,
                             bit drain = 1'b0);
    element_t e;
    e.fmt = fmt;
    e.lo = lo;
    e.hi = hi;
    e.drain = drain;
    pending_elements.push_back(e);
  endtask

  function automatic logic [15:0] random_half();
    logic [15:0] x;
    x = 16'($urandom);
    case ($urandom_range(0, 3))
      0: x[14:10] = 5'd0;
      1: x[14:10] = 5'h1F;
      default: ;
    endcase
    return x;
  endfunction

  // driver
  always @(negedge clk) begin
    logic next_valid;
    element_t e;
    next_valid = in_valid;
    if (rst_n && (!in_valid || item_taken)) begin
      next_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_elements.size() > 0 &&
                   (!pending_elements[0].drain || expected_components.size() == 0)) begin
        e = pending_elements.pop_front();
        in_format_code <= e.fmt;
        in_raw_low <= e.lo;
        in_raw_high <= e.hi;
        next_valid = 1'b1;
        if (!tail_phase && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 13);
      end
    end
    in_valid <= next_valid;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    vau_result_t want;
    logic [3:0][31:0] got_c, want_c;
    item_taken = rst_n && in_valid && !in_stall;
    if (item_taken)
      expected_components.push_back(convert_element(in_format_code, in_raw_low, in_raw_high));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_components.size() == 0) begin
        $display("%0t: result item with none expected, actual %h %h %h %h", $time,
                 out_comp_x, out_comp_y, out_comp_z, out_comp_w);
        error_count++;
      end else begin
        want = expected_components.pop_front();
        want_c = want;
        got_c = {out_comp_x, out_comp_y, out_comp_z, out_comp_w};
        for (int i = 3; i >= 0; i--)
          if (got_c[i] !== want_c[i]) begin
            $display("%0t: component %0d expected %h actual %h", $time, 3 - i,
                     want_c[i], got_c[i]);
            error_count++;
          end
      end
    end
    if (item_taken || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 3000) begin
      $display("vertex_attribute_unpack test failed");
      $finish;
    end
  end

  initial begin
    logic [4:0] fmt;
    // directed: extremes, half specials, snorm minimum, unsupported codes
    for (int f = 0; f <= 18; f++) begin
      add_element(f[4:0], '0, '0);
      add_element(f[4:0], '1, '1);
    end
    add_element(FMT_R16G16B16A16_FLOAT, 64'h7E01_FC00_7C00_0001, '0);
    add_element(FMT_R16G16B16A16_FLOAT, 64'h3C00_8000_03FF_83FF, '0);
    add_element(FMT_R16G16_FLOAT, 64'h0000_0000_FFFF_0400, '0);
    add_element(FMT_R8G8B8A8_SNORM, 64'h0000_0000_7F80_8100, '1);
    add_element(FMT_R16G16_SNORM, 64'hFFFF_FFFF_7FFF_8000, '0);
    add_element(FMT_R16G16_SINT, 64'h0000_0000_7FFF_8000, '0);
    add_element(FMT_R10G10B10A2_UNORM, 64'h0000_0000_C010_0401, '0);
    add_element(FMT_B8G8R8X8_UNORM, 64'h0000_0000_8040_2010, '0);
    add_element(5'd19, '1, '1);
    add_element(5'd31, '1, '1);
    for (int n = 0; n < 1800; n++) begin
      fmt = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(19, 31))
                                         : 5'($urandom_range(0, 18));
      if (fmt == FMT_R16G16B16A16_FLOAT || fmt == FMT_R16G16_FLOAT)
        add_element(fmt, {random_half(), random_half(), random_half(), random_half()},
                    {$urandom, $urandom}, n == 900);
      else
        add_element(fmt, {$urandom, $urandom}, {$urandom, $urandom}, n == 900);
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    while (pending_elements.size() > 150) @(posedge clk);
    tail_phase = 1'b1;
    while (pending_elements.size() > 0 || in_valid || expected_components.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0 && expected_components.size() == 0)
      $display("vertex_attribute_unpack test passed");
    else
      $display("vertex_attribute_unpack test failed");
    $finish;
  end
endmodule
